### rtl/ccrf_pkg.sv
// Types, address map, write masks and port-base decode for the config register block.
`timescale 1ns / 1ps

package ccrf_pkg;

	localparam int NWORDS = 21;
	localparam int IDX_W = $clog2(NWORDS);

	localparam int IDX_REFRESH = 2;
	localparam int IDX_DISK = 3;
	localparam int IDX_PMC = 12;
	localparam int IDX_EMS_PTR = 19;
	localparam int IDX_EMS_PAGE = 20;

	localparam logic CMD_READ = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [15:0] ADDR_PMC_LO = 16'h7072;
	localparam logic [15:0] ADDR_PMC_HI = 16'h7872;
	localparam logic [15:0] ADDR_OSC_OFF = 16'hf072;
	localparam logic [15:0] ADDR_OSC_ON = 16'hf472;
	localparam logic [15:0] ADDR_EMS_PTR = 16'he072;
	localparam logic [15:0] ADDR_EMS_PAGE = 16'he872;
	localparam logic [15:0] ADDR_LOCK = 16'hf073;
	localparam logic [15:0] ADDR_SHADOW = 16'hd072;
	localparam logic [15:0] ADDR_LOCK_STAT = 16'hfc72;

	localparam logic [15:0] LOCK_STAT_VAL = 16'h0ff0;
	localparam logic [15:0] LOCK_KEY_MASK = 16'h00da;
	localparam logic [15:0] READ_MISS = 16'hffff;

	localparam logic [15:0] REG_ADDR [NWORDS] = '{
		16'h1072, 16'h1872, 16'h2072, 16'h2872, 16'h3072, 16'h3872, 16'h4072,
		16'h4872, 16'h5072, 16'h5872, 16'h6072, 16'h6872, 16'h0000, 16'h8072,
		16'h8872, 16'h9072, 16'h9872, 16'ha072, 16'hc872, 16'he072, 16'he872
	};

	localparam logic [15:0] REG_MASK [NWORDS] = '{
		16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
		16'hffff, 16'hffff, 16'hffff, 16'hffbf, 16'hecff, 16'hffff, 16'hffff,
		16'hffff, 16'h00fc, 16'hfdff, 16'hffff, 16'hfcfc, 16'h003f, 16'h8fff
	};

	localparam logic [9:0] IDE_BASE_PRI = 10'h1f0;
	localparam logic [9:0] IDE_BASE_SEC = 10'h170;
	localparam logic [9:0] IDE_CTRL_PRI = 10'h3f6;
	localparam logic [9:0] IDE_CTRL_SEC = 10'h376;

	typedef struct packed {
		logic        cmd;
		logic [15:0] io_addr;
		logic [15:0] wdata;
	} ccrf_req_t;

	typedef struct packed {
		logic [15:0] rdata;
		logic        locked;
		logic [9:0]  uart_a_port;
		logic [9:0]  uart_b_port;
		logic [9:0]  lpt_port;
		logic [9:0]  ide_base;
		logic [9:0]  ide_ctrl_port;
		logic        fdc_enabled;
		logic        disk_secondary;
		logic        osc_40mhz;
	} ccrf_rsp_t;

	function automatic logic [9:0] uart_base(input logic [2:0] code);
		logic [9:0] base;
		case (code)
			3'd1: base = 10'h3f8;
			3'd2: base = 10'h2f8;
			3'd3: base = 10'h3e8;
			3'd4: base = 10'h2e8;
			default: base = 10'h000;
		endcase
		return base;
	endfunction

	function automatic logic [9:0] lpt_base(input logic [1:0] code);
		logic [9:0] base;
		case (code)
			2'd1: base = 10'h3bc;
			2'd2: base = 10'h378;
			2'd3: base = 10'h278;
			default: base = 10'h000;
		endcase
		return base;
	endfunction

endpackage

### rtl/chipset_config_register_file_unit.sv
// Top level of the chipset configuration register block.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   ccrf_req_t (cmd, io_addr, wdata)
//   rsp      out  rsp_valid/rsp_stall   ccrf_rsp_t (rdata, lock and port decode)
//
// One word per cycle sustained while rsp_stall is low; a request passes the request register,
// then the register file, which forms the response combinationally and updates its words on
// the edge that loads the response register; the response register parts the two sides.
// Reset locks the gated registers, clears all config words and the oscillator flag.
// A stalled response holds the request register; a new request is taken whenever it drains.
`timescale 1ns / 1ps

module chipset_config_register_file_unit import ccrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  ccrf_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ccrf_rsp_t rsp
);

	logic      adv;
	logic      valid_s1;
	logic      fire;
	ccrf_req_t item_s1;
	ccrf_rsp_t result;

	assign fire = valid_s1 && adv;

	ccrf_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	ccrf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	ccrf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.result    (result),
		.adv       (adv),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("processed word did not reach the response register");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid && rsp_stall)
		else $error("request stalled without a blocked word ahead");

	a_ide_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ide_base == 10'h000 |-> rsp.ide_ctrl_port == 10'h000)
		else $error("IDE control port decoded while IDE base is disabled");

	a_ide_secondary: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ide_base != 10'h000 && rsp.disk_secondary
		|-> rsp.ide_base == IDE_BASE_SEC && rsp.ide_ctrl_port == IDE_CTRL_SEC)
		else $error("secondary disk select gave a primary IDE address");
`endif

endmodule

### rtl/ccrf_in_stage.sv
// Input register stage: captures one request word and holds it until it is processed.
`timescale 1ns / 1ps

module ccrf_in_stage import ccrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  ccrf_req_t req,
	output logic      req_stall,
	input  logic      adv,
	output logic      valid_s1,
	output ccrf_req_t item_s1
);

	logic load;

	assign req_stall = valid_s1 && !adv;
	assign load = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= req;
		end
	end

endmodule

### rtl/ccrf_regs.sv
// Configuration register file: decode, masked update, read mux and port-base decode.
`timescale 1ns / 1ps

module ccrf_regs import ccrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  ccrf_req_t item,
	output ccrf_rsp_t result
);

	logic [15:0]      words_q [NWORDS];
	logic [15:0]      words_n [NWORDS];
	logic             lock_q;
	logic             lock_n;
	logic             osc_q;
	logic             osc_n;
	logic             hit;
	logic [IDX_W-1:0] idx;
	logic [15:0]      rdata;
	logic [15:0]      rc;
	logic [15:0]      dcs;

	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = 0; i < NWORDS; i++) begin
			if (i != IDX_PMC && !hit && item.io_addr == REG_ADDR[i]) begin
				hit = 1'b1;
				idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		words_n = words_q;
		lock_n = lock_q;
		osc_n = osc_q;
		rdata = '0;
		if (item.cmd == CMD_WRITE) begin
			if (!lock_q) begin
				if (item.io_addr == ADDR_PMC_LO) begin
					words_n[IDX_PMC] = {8'h00, item.wdata[15:8]};
				end else if (item.io_addr == ADDR_PMC_HI) begin
					words_n[IDX_PMC] = {item.wdata[15:8], 8'h00};
				end else if (item.io_addr == ADDR_OSC_OFF) begin
					osc_n = 1'b0;
				end else if (item.io_addr == ADDR_OSC_ON) begin
					osc_n = 1'b1;
				end else if (hit && idx < IDX_W'(IDX_EMS_PTR)) begin
					words_n[idx] = item.wdata & REG_MASK[idx];
				end
			end
			if (item.io_addr == ADDR_EMS_PTR) begin
				words_n[IDX_EMS_PTR] = item.wdata & REG_MASK[IDX_EMS_PTR];
			end else if (item.io_addr == ADDR_EMS_PAGE) begin
				words_n[IDX_EMS_PAGE] = item.wdata & REG_MASK[IDX_EMS_PAGE];
			end else if (item.io_addr == ADDR_LOCK) begin
				lock_n = (item.wdata & LOCK_KEY_MASK) == 16'h0000;
			end
		end else begin
			if (item.io_addr == ADDR_PMC_LO) begin
				rdata = {words_q[IDX_PMC][7:0], 8'h00};
			end else if (item.io_addr == ADDR_PMC_HI) begin
				rdata = {words_q[IDX_PMC][15:8], 8'h00};
			end else if (item.io_addr == ADDR_SHADOW) begin
				rdata = 16'h0000;
			end else if (item.io_addr == ADDR_LOCK_STAT) begin
				rdata = LOCK_STAT_VAL;
			end else if (hit) begin
				rdata = words_q[idx];
			end else begin
				rdata = READ_MISS;
			end
		end
	end

	assign rc = words_n[IDX_REFRESH];
	assign dcs = words_n[IDX_DISK];

	always_comb begin
		result.rdata = rdata;
		result.locked = lock_n;
		result.uart_a_port = uart_base(rc[7:5]);
		result.uart_b_port = uart_base(rc[3:1]);
		result.lpt_port = lpt_base(rc[10:9]);
		result.ide_base = dcs[0] ? 10'h000 : (dcs[4] ? IDE_BASE_SEC : IDE_BASE_PRI);
		result.ide_ctrl_port = dcs[0] ? 10'h000 : (dcs[4] ? IDE_CTRL_SEC : IDE_CTRL_PRI);
		result.fdc_enabled = !dcs[1];
		result.disk_secondary = dcs[4];
		result.osc_40mhz = osc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NWORDS; i++) begin
				words_q[i] <= '0;
			end
			lock_q <= 1'b1;
			osc_q <= 1'b0;
		end else if (fire) begin
			words_q <= words_n;
			lock_q <= lock_n;
			osc_q <= osc_n;
		end
	end

endmodule

### rtl/ccrf_out_stage.sv
// Result register stage: holds one response word until the receiver takes it.
`timescale 1ns / 1ps

module ccrf_out_stage import ccrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  ccrf_rsp_t result,
	output logic      adv,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ccrf_rsp_t rsp
);

	assign adv = !rsp_valid || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp <= result;
		end
	end

endmodule

### dv/chipset_config_register_file_unit_tb.sv
// Self-checking testbench for the chipset configuration register block.
`timescale 1ns / 1ps

module chipset_config_register_file_unit_tb;
	import ccrf_pkg::*;

	localparam logic [15:0] ADDR_FLUSH = 16'hf872;
	localparam logic [15:0] ADDR_SPARE_B8 = 16'hb872;
	localparam logic [15:0] ADDR_SPARE_C0 = 16'hc072;
	localparam int RANDOM_WORDS = 1950;
	localparam int TAIL_WORDS = 200;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 60;

	typedef struct {
		ccrf_req_t word;
		bit        drain_first;
	} pending_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	ccrf_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	ccrf_rsp_t rsp;

	pending_t       pending_words[$];
	ccrf_rsp_t      expected_rsp[$];
	logic [15:0]    port_pool[$];
	int unsigned    mismatches = 0;
	int unsigned    rsp_seen = 0;
	int unsigned    total_words = 0;

	logic [15:0] cfg_words [NWORDS];
	logic        lock_on;
	logic [7:0]  lock_byte;
	logic        osc_on;
	logic [15:0] flush_val;

	chipset_config_register_file_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("chipset_config_register_file_unit verification failed");
		$finish;
	end

	function automatic int reg_index(logic [15:0] a);
		for (int i = 0; i < NWORDS; i++) begin
			if (i != IDX_PMC && REG_ADDR[i] == a) begin
				return i;
			end
		end
		return NWORDS;
	endfunction

	function automatic logic [9:0] serial_base(logic [2:0] code);
		logic [9:0] b;
		case (code)
			3'd1: b = 10'h3f8;
			3'd2: b = 10'h2f8;
			3'd3: b = 10'h3e8;
			3'd4: b = 10'h2e8;
			default: b = 10'h000;
		endcase
		return b;
	endfunction

	function automatic ccrf_rsp_t apply_access(ccrf_req_t w);
		ccrf_rsp_t r;
		int idx;
		logic [15:0] a;
		logic [15:0] v;
		logic [15:0] rc;
		logic [15:0] dcs;
		a = w.io_addr;
		v = w.wdata;
		r = '0;
		if (w.cmd == CMD_WRITE) begin
			if (!lock_on) begin
				if (a == ADDR_PMC_LO) begin
					cfg_words[IDX_PMC] = {8'h00, v[15:8]};
				end else if (a == ADDR_PMC_HI) begin
					cfg_words[IDX_PMC] = {v[15:8], 8'h00};
				end else if (a == ADDR_OSC_OFF) begin
					osc_on = 1'b0;
				end else if (a == ADDR_OSC_ON) begin
					osc_on = 1'b1;
				end else if (a == ADDR_FLUSH) begin
					flush_val = v;
				end else begin
					idx = reg_index(a);
					if (idx < IDX_EMS_PTR) begin
						cfg_words[idx] = v & REG_MASK[idx];
					end
				end
			end
			if (a == ADDR_EMS_PTR) begin
				cfg_words[IDX_EMS_PTR] = v & REG_MASK[IDX_EMS_PTR];
			end else if (a == ADDR_EMS_PAGE) begin
				cfg_words[IDX_EMS_PAGE] = v & REG_MASK[IDX_EMS_PAGE];
			end else if (a == ADDR_LOCK) begin
				lock_byte = v[7:0];
				lock_on = ((v & LOCK_KEY_MASK) == 16'h0000);
			end
		end else begin
			idx = reg_index(a);
			if (a == ADDR_PMC_LO) begin
				r.rdata = {cfg_words[IDX_PMC][7:0], 8'h00};
			end else if (a == ADDR_PMC_HI) begin
				r.rdata = {cfg_words[IDX_PMC][15:8], 8'h00};
			end else if (a == ADDR_SHADOW) begin
				r.rdata = 16'h0000;
			end else if (a == ADDR_LOCK_STAT) begin
				r.rdata = LOCK_STAT_VAL;
			end else if (idx < NWORDS) begin
				r.rdata = cfg_words[idx];
			end else begin
				r.rdata = READ_MISS;
			end
		end
		rc = cfg_words[IDX_REFRESH];
		dcs = cfg_words[IDX_DISK];
		r.locked = lock_on;
		r.uart_a_port = serial_base(rc[7:5]);
		r.uart_b_port = serial_base(rc[3:1]);
		case (rc[10:9])
			2'd1: r.lpt_port = 10'h3bc;
			2'd2: r.lpt_port = 10'h378;
			2'd3: r.lpt_port = 10'h278;
			default: r.lpt_port = 10'h000;
		endcase
		r.ide_base = dcs[0] ? 10'h000 : (dcs[4] ? IDE_BASE_SEC : IDE_BASE_PRI);
		r.ide_ctrl_port = dcs[0] ? 10'h000 : (dcs[4] ? IDE_CTRL_SEC : IDE_CTRL_PRI);
		r.fdc_enabled = ~dcs[1];
		r.disk_secondary = dcs[4];
		r.osc_40mhz = osc_on;
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		$display("MISMATCH word %0d %s: got %h want %h", rsp_seen, what, got, want);
	endtask

	task automatic queue_word(logic c, logic [15:0] a, logic [15:0] v, bit drain);
		pending_t p;
		p.word.cmd = c;
		p.word.io_addr = a;
		p.word.wdata = v;
		p.drain_first = drain;
		pending_words.push_back(p);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		int unsigned gap_left;
		logic        nv;
		ccrf_req_t   nreq;
		pending_t    p;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left = 0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_rsp.push_back(apply_access(req));
			end
			if (!req_valid || !req_stall) begin
				nv = 1'b0;
				nreq = req;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() == 0) begin
					nv = 1'b0;
				end else if (pending_words[0].drain_first && expected_rsp.size() != 0) begin
					nv = 1'b0;
				end else if (pending_words.size() > TAIL_WORDS &&
						$urandom_range(0, 15) == 0) begin
					gap_left = $urandom_range(1, 10) - 1;
				end else begin
					p = pending_words.pop_front();
					nv = 1'b1;
					nreq = p.word;
				end
				req_valid <= nv;
				req <= nreq;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		int unsigned hold_left;
		int unsigned stall_left;
		bit          hold_done;
		logic        ns;
		ccrf_rsp_t   want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left = 0;
			stall_left = 0;
			hold_done = 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					note_mismatch("unexpected word", rsp.rdata, 16'h0000);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.rdata !== want.rdata)
						note_mismatch("rdata", rsp.rdata, want.rdata);
					if (rsp.locked !== want.locked)
						note_mismatch("locked", 16'(rsp.locked), 16'(want.locked));
					if (rsp.uart_a_port !== want.uart_a_port)
						note_mismatch("uart_a_port", 16'(rsp.uart_a_port),
							16'(want.uart_a_port));
					if (rsp.uart_b_port !== want.uart_b_port)
						note_mismatch("uart_b_port", 16'(rsp.uart_b_port),
							16'(want.uart_b_port));
					if (rsp.lpt_port !== want.lpt_port)
						note_mismatch("lpt_port", 16'(rsp.lpt_port), 16'(want.lpt_port));
					if (rsp.ide_base !== want.ide_base)
						note_mismatch("ide_base", 16'(rsp.ide_base), 16'(want.ide_base));
					if (rsp.ide_ctrl_port !== want.ide_ctrl_port)
						note_mismatch("ide_ctrl_port", 16'(rsp.ide_ctrl_port),
							16'(want.ide_ctrl_port));
					if (rsp.fdc_enabled !== want.fdc_enabled)
						note_mismatch("fdc_enabled", 16'(rsp.fdc_enabled),
							16'(want.fdc_enabled));
					if (rsp.disk_secondary !== want.disk_secondary)
						note_mismatch("disk_secondary", 16'(rsp.disk_secondary),
							16'(want.disk_secondary));
					if (rsp.osc_40mhz !== want.osc_40mhz)
						note_mismatch("osc_40mhz", 16'(rsp.osc_40mhz), 16'(want.osc_40mhz));
				end
				rsp_seen++;
			end
			ns = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				ns = 1'b1;
			end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				ns = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				ns = 1'b1;
			end else if (rsp_seen + TAIL_WORDS < total_words &&
					$urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				ns = 1'b1;
			end
			rsp_stall <= ns;
		end
	end

	initial begin
		int unsigned pick;
		logic        c;
		logic [15:0] a;
		logic [15:0] v;
		for (int i = 0; i < NWORDS; i++) begin
			cfg_words[i] = 16'h0000;
			if (i != IDX_PMC)
				port_pool.push_back(REG_ADDR[i]);
		end
		lock_on = 1'b1;
		lock_byte = 8'h00;
		osc_on = 1'b0;
		flush_val = 16'h0000;
		port_pool.push_back(ADDR_PMC_LO);
		port_pool.push_back(ADDR_PMC_HI);
		port_pool.push_back(ADDR_OSC_OFF);
		port_pool.push_back(ADDR_OSC_ON);
		port_pool.push_back(ADDR_FLUSH);
		port_pool.push_back(ADDR_SHADOW);
		port_pool.push_back(ADDR_LOCK_STAT);
		port_pool.push_back(ADDR_SPARE_B8);
		port_pool.push_back(ADDR_SPARE_C0);
		port_pool.push_back(ADDR_LOCK);
		port_pool.push_back(16'h0000);

		// directed: locked after reset, unlock, masks, PMC packing, oscillator, relock
		queue_word(CMD_READ, REG_ADDR[0], 16'hffff, 0);
		queue_word(CMD_WRITE, REG_ADDR[IDX_REFRESH], 16'hffff, 0);
		queue_word(CMD_WRITE, ADDR_OSC_ON, 16'h0000, 0);
		queue_word(CMD_READ, ADDR_LOCK_STAT, 16'h0000, 0);
		queue_word(CMD_READ, ADDR_SHADOW, 16'hffff, 0);
		queue_word(CMD_READ, 16'h0000, 16'h0000, 0);
		queue_word(CMD_WRITE, ADDR_LOCK, LOCK_KEY_MASK, 0);
		queue_word(CMD_WRITE, REG_ADDR[IDX_REFRESH], 16'hffff, 0);
		queue_word(CMD_WRITE, REG_ADDR[IDX_DISK], 16'hffff, 0);
		queue_word(CMD_WRITE, REG_ADDR[10], 16'hffff, 0);
		queue_word(CMD_WRITE, REG_ADDR[15], 16'hffff, 0);
		queue_word(CMD_WRITE, ADDR_PMC_LO, 16'habcd, 0);
		queue_word(CMD_READ, ADDR_PMC_LO, 16'h0000, 0);
		queue_word(CMD_READ, ADDR_PMC_HI, 16'h0000, 0);
		queue_word(CMD_WRITE, ADDR_PMC_HI, 16'hffff, 0);
		queue_word(CMD_READ, ADDR_PMC_LO, 16'hffff, 0);
		queue_word(CMD_WRITE, ADDR_OSC_ON, 16'hffff, 0);
		queue_word(CMD_WRITE, ADDR_FLUSH, 16'h1234, 0);
		queue_word(CMD_READ, ADDR_FLUSH, 16'h0000, 0);
		queue_word(CMD_WRITE, ADDR_LOCK, 16'hff25, 0);
		queue_word(CMD_WRITE, ADDR_EMS_PTR, 16'hffff, 0);
		queue_word(CMD_WRITE, ADDR_EMS_PAGE, 16'hffff, 0);
		queue_word(CMD_READ, ADDR_EMS_PAGE, 16'h0000, 0);
		queue_word(CMD_WRITE, REG_ADDR[IDX_DISK], 16'h0000, 0);
		queue_word(CMD_READ, 16'hffff, 16'hffff, 0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			c = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 7))
				0: v = 16'h0000;
				1: v = 16'hffff;
				default: v = 16'($urandom);
			endcase
			if (pick < 12) begin
				c = CMD_WRITE;
				a = ADDR_LOCK;
				if ($urandom_range(0, 1) == 0) begin
					v = v & ~LOCK_KEY_MASK;
				end else if ((v & LOCK_KEY_MASK) == 16'h0000) begin
					v = v | 16'h0002;
				end
			end else if (pick < 72) begin
				a = port_pool[$urandom_range(0, port_pool.size() - 1)];
			end else begin
				a = 16'($urandom_range(0, 65535));
			end
			queue_word(c, a, v, (n % 300) == 150);
		end
		total_words = pending_words.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("chipset_config_register_file_unit verification clean");
		end else begin
			$display("chipset_config_register_file_unit verification failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/ccrf_pkg.sv
rtl/ccrf_in_stage.sv
rtl/ccrf_regs.sv
rtl/ccrf_out_stage.sv
rtl/chipset_config_register_file_unit.sv
dv/chipset_config_register_file_unit_tb.sv
